@@ rtl/core/dea_pkg.sv @@
// Shared types and codes for the doorbell event allocator.
package dea_pkg;

    localparam int EVENT_NUM_W = 10;
    localparam int TOKEN_W     = 32;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RING  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_TOP   = 8'b0000_0100,
        S_MID   = 8'b0000_1000,
        S_LOW   = 8'b0001_0000,
        S_LOOK  = 8'b0010_0000,
        S_CHECK = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic top_step;
        logic mid_step;
        logic low_step;
        logic look_step;
        logic check_step;
        logic load;
    } dea_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic req_alloc;
        logic top_full;
        logic out_free;
    } dea_stat_t;

endpackage

@@ rtl/core/doorbell_event_allocator_core.sv @@
// Top level of the doorbell event allocator.
// The input channel (in_valid/in_ready) carries one request item: allocate, free or ring.
// The output channel (out_valid/out_ready) returns exactly one result item per request.
// Allocate finds the lowest free event by walking a three-level occupancy tree: a
// register of full flags for summary words, a summary RAM of full flags for occupancy
// words, and the occupancy RAM itself; each of the two RAM levels costs one RAM read.
// An allocate steps through the top, mid and low states before its result is loaded.
// An allocate that finds every event in use goes from the top state straight to done.
// Free, ring and reserved requests pass through the look and check states: one
// occupancy RAM read and a check.
// The block works on one item at a time and accepts the next item as soon as the
// result has moved into the output register, even while that result still waits.
// When the receiver stalls, the finished result holds the output and the next item
// waits in its last step until the output register frees up.
// After reset the occupancy and summary RAMs are cleared, one occupancy word per cycle;
// in_ready stays low during that pass. The token store is not cleared; its read data
// is only used for events that are in use.
module doorbell_event_allocator_core
    import dea_pkg::*;
#(
    parameter int EVENT_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [EVENT_NUM_W-1:0] event_number,
    input  logic [TOKEN_W-1:0]     handler_token,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [EVENT_NUM_W-1:0] granted_event,
    output logic [TOKEN_W-1:0]     token_out,
    output logic                   ring_hit
);

    dea_cmd_t  cmd;
    dea_stat_t stat;

    dea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dea_datapath #(
        .EVENT_BITS (EVENT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .event_number  (event_number),
        .handler_token (handler_token),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_event (granted_event),
        .token_out     (token_out),
        .ring_hit      (ring_hit)
    );

endmodule

@@ rtl/core/dea_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/dea_ctrl.sv @@
// Controller state machine of the doorbell event allocator.
module dea_ctrl
    import dea_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dea_stat_t stat,
    output dea_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.req_alloc ? S_TOP : S_LOOK;
                end
            end
            S_TOP:
            begin
                cmd.top_step = 1'b1;
                state_next   = stat.top_full ? S_DONE : S_MID;
            end
            S_MID:
            begin
                cmd.mid_step = 1'b1;
                state_next   = S_LOW;
            end
            S_LOW:
            begin
                cmd.low_step = 1'b1;
                state_next   = S_DONE;
            end
            S_LOOK:
            begin
                cmd.look_step = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check_step = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/core/dea_datapath.sv @@
// Datapath of the doorbell event allocator: occupancy tree, token store and result registers.
module dea_datapath
    import dea_pkg::*;
#(
    parameter int EVENT_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dea_cmd_t               cmd,
    output dea_stat_t              stat,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [EVENT_NUM_W-1:0] event_number,
    input  logic [TOKEN_W-1:0]     handler_token,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [EVENT_NUM_W-1:0] granted_event,
    output logic [TOKEN_W-1:0]     token_out,
    output logic                   ring_hit
);

    localparam int LOW_BITS   = (EVENT_BITS + 2) / 3;
    localparam int MID_BITS   = (EVENT_BITS - LOW_BITS + 1) / 2;
    localparam int TOP_BITS   = EVENT_BITS - LOW_BITS - MID_BITS;
    localparam int LOW_W      = 1 << LOW_BITS;
    localparam int MID_W      = 1 << MID_BITS;
    localparam int TOP_W      = 1 << TOP_BITS;
    localparam int OCC_AW     = TOP_BITS + MID_BITS;
    localparam int OCC_DEPTH  = 1 << OCC_AW;
    localparam int EVENT_CNT  = 1 << EVENT_BITS;
    localparam int WIDE_BITS  = (EVENT_BITS > EVENT_NUM_W) ? EVENT_BITS : EVENT_NUM_W;

    logic [REQ_W-1:0]       req_reg;
    logic [EVENT_NUM_W-1:0] ev_reg;
    logic [EVENT_BITS-1:0]  idx_reg;
    logic                   inr_reg;
    logic [TOKEN_W-1:0]     tok_reg;
    logic [TOP_W-1:0]       top_full_reg;
    logic [TOP_W-1:0]       top_full_next;
    logic [TOP_BITS-1:0]    t_sel_reg;
    logic [MID_BITS-1:0]    m_sel_reg;
    logic [OCC_AW-1:0]      clr_cnt_reg;

    logic [STATUS_W-1:0]    res_status_reg;
    logic [EVENT_NUM_W-1:0] res_event_reg;
    logic [TOKEN_W-1:0]     res_token_reg;
    logic                   res_hit_reg;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [EVENT_NUM_W-1:0] out_event_reg;
    logic [TOKEN_W-1:0]     out_token_reg;
    logic                   out_hit_reg;

    logic                   occ_we;
    logic [OCC_AW-1:0]      occ_waddr;
    logic [LOW_W-1:0]       occ_wdata;
    logic                   occ_re;
    logic [OCC_AW-1:0]      occ_raddr;
    logic [LOW_W-1:0]       occ_rdata;

    logic                   sum_we;
    logic [TOP_BITS-1:0]    sum_waddr;
    logic [MID_W-1:0]       sum_wdata;
    logic                   sum_re;
    logic [TOP_BITS-1:0]    sum_raddr;
    logic [MID_W-1:0]       sum_rdata;

    logic                   tok_we;
    logic [EVENT_BITS-1:0]  tok_waddr;
    logic                   tok_re;
    logic [TOKEN_W-1:0]     tok_rdata;

    logic [TOP_BITS-1:0]    top_idx;
    logic [MID_BITS-1:0]    mid_idx;
    logic [LOW_BITS-1:0]    low_idx;
    logic [WIDE_BITS-1:0]   in_wide;
    logic                   in_range;
    logic [EVENT_BITS-1:0]  alloc_idx;
    logic [WIDE_BITS-1:0]   alloc_wide;
    logic [LOW_W-1:0]       occ_set;
    logic [MID_W-1:0]       sum_set;
    logic                   ev_active;
    logic                   out_free;

    assign in_wide    = WIDE_BITS'(event_number);
    assign in_range   = (in_wide >> EVENT_BITS) == WIDE_BITS'(0);
    assign alloc_idx  = {t_sel_reg, m_sel_reg, low_idx};
    assign alloc_wide = WIDE_BITS'(alloc_idx);
    assign occ_set    = occ_rdata | (LOW_W'(1) << low_idx);
    assign sum_set    = sum_rdata | (MID_W'(1) << m_sel_reg);
    assign ev_active  = inr_reg && occ_rdata[idx_reg[LOW_BITS-1:0]];
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        top_idx = '0;
        for (int i = TOP_W - 1; i >= 0; i--)
        begin
            if (!top_full_reg[i])
            begin
                top_idx = TOP_BITS'(i);
            end
        end
    end

    always_comb
    begin
        mid_idx = '0;
        for (int i = MID_W - 1; i >= 0; i--)
        begin
            if (!sum_rdata[i])
            begin
                mid_idx = MID_BITS'(i);
            end
        end
    end

    always_comb
    begin
        low_idx = '0;
        for (int i = LOW_W - 1; i >= 0; i--)
        begin
            if (!occ_rdata[i])
            begin
                low_idx = LOW_BITS'(i);
            end
        end
    end

    always_comb
    begin
        occ_we        = 1'b0;
        occ_waddr     = idx_reg[EVENT_BITS-1:LOW_BITS];
        occ_wdata     = occ_rdata & ~(LOW_W'(1) << idx_reg[LOW_BITS-1:0]);
        occ_re        = 1'b0;
        occ_raddr     = idx_reg[EVENT_BITS-1:LOW_BITS];
        sum_we        = 1'b0;
        sum_waddr     = idx_reg[EVENT_BITS-1:EVENT_BITS-TOP_BITS];
        sum_wdata     = sum_rdata & ~(MID_W'(1) << idx_reg[LOW_BITS+MID_BITS-1:LOW_BITS]);
        sum_re        = 1'b0;
        sum_raddr     = idx_reg[EVENT_BITS-1:EVENT_BITS-TOP_BITS];
        tok_we        = 1'b0;
        tok_waddr     = alloc_idx;
        tok_re        = 1'b0;
        top_full_next = top_full_reg;
        if (cmd.clr_step)
        begin
            occ_we    = 1'b1;
            occ_waddr = clr_cnt_reg;
            occ_wdata = '0;
            sum_we    = 1'b1;
            sum_waddr = clr_cnt_reg[OCC_AW-1:MID_BITS];
            sum_wdata = '0;
        end
        if (cmd.top_step)
        begin
            sum_re    = 1'b1;
            sum_raddr = top_idx;
        end
        if (cmd.mid_step)
        begin
            occ_re    = 1'b1;
            occ_raddr = {t_sel_reg, mid_idx};
        end
        if (cmd.low_step)
        begin
            occ_we    = 1'b1;
            occ_waddr = {t_sel_reg, m_sel_reg};
            occ_wdata = occ_set;
            tok_we    = 1'b1;
            if (&occ_set)
            begin
                sum_we    = 1'b1;
                sum_waddr = t_sel_reg;
                sum_wdata = sum_set;
                if (&sum_set)
                begin
                    top_full_next[t_sel_reg] = 1'b1;
                end
            end
        end
        if (cmd.look_step)
        begin
            occ_re = 1'b1;
            sum_re = 1'b1;
            tok_re = 1'b1;
        end
        if (cmd.check_step && (req_reg == REQ_FREE) && ev_active)
        begin
            occ_we = 1'b1;
            sum_we = 1'b1;
            top_full_next[idx_reg[EVENT_BITS-1:EVENT_BITS-TOP_BITS]] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            top_full_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + OCC_AW'(1);
            end
            top_full_reg <= top_full_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req_type;
            ev_reg  <= event_number;
            idx_reg <= in_wide[EVENT_BITS-1:0];
            inr_reg <= in_range;
            tok_reg <= handler_token;
        end
        if (cmd.top_step)
        begin
            t_sel_reg      <= top_idx;
            res_status_reg <= ST_FULL;
            res_event_reg  <= '0;
            res_token_reg  <= '0;
            res_hit_reg    <= 1'b0;
        end
        if (cmd.mid_step)
        begin
            m_sel_reg <= mid_idx;
        end
        if (cmd.low_step)
        begin
            res_status_reg <= ST_OK;
            res_event_reg  <= alloc_wide[EVENT_NUM_W-1:0];
        end
        if (cmd.check_step)
        begin
            res_event_reg <= ev_reg;
            res_token_reg <= '0;
            res_hit_reg   <= 1'b0;
            priority if (req_reg == REQ_FREE)
            begin
                res_status_reg <= ev_active ? ST_OK : ST_NOT_ALLOC;
            end
            else if (req_reg == REQ_RING)
            begin
                res_status_reg <= ev_active ? ST_OK : ST_NOT_ALLOC;
                res_token_reg  <= ev_active ? tok_rdata : '0;
                res_hit_reg    <= ev_active;
            end
            else
            begin
                res_status_reg <= ST_OK;
            end
        end
        if (cmd.load)
        begin
            out_status_reg <= res_status_reg;
            out_event_reg  <= res_event_reg;
            out_token_reg  <= res_token_reg;
            out_hit_reg    <= res_hit_reg;
        end
    end

    dea_ram #(
        .WIDTH (LOW_W),
        .DEPTH (OCC_DEPTH)
    ) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .re    (occ_re),
        .raddr (occ_raddr),
        .rdata (occ_rdata)
    );

    dea_ram #(
        .WIDTH (MID_W),
        .DEPTH (TOP_W)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    dea_ram #(
        .WIDTH (TOKEN_W),
        .DEPTH (EVENT_CNT)
    ) u_tok_ram (
        .clk   (clk),
        .we    (tok_we),
        .waddr (tok_waddr),
        .wdata (tok_reg),
        .re    (tok_re),
        .raddr (idx_reg),
        .rdata (tok_rdata)
    );

    assign stat.clr_last  = &clr_cnt_reg;
    assign stat.req_alloc = (req_type == REQ_ALLOC);
    assign stat.top_full  = &top_full_reg;
    assign stat.out_free  = out_free;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_event = out_event_reg;
    assign token_out     = out_token_reg;
    assign ring_hit      = out_hit_reg;

endmodule
